FILE: src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/tlvss_pkg.sv
// shared constants and types for the tlv stream scanner
`default_nettype none

package tlvss_pkg;

    localparam int HEADER_BYTES_DEF      = 7;
    localparam int MAX_MESSAGE_BYTES_DEF = 4096;
    localparam int MIN_BODY_BYTES        = 4;

    localparam int POS_W    = 12;
    localparam int HDR_W    = 4;
    localparam int PHASE_W  = 3;
    localparam int LEN_W    = 16;
    localparam int STATUS_W = 2;

    localparam logic [PHASE_W-1:0] PH_HEADER  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ID      = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_LO  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN_HI  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERRUN = 2'd2;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    found_offset;
        logic [POS_W-1:0]    record_count;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

`default_nettype wire

FILE: src/tlvss_parse.sv
// per-byte message parser: header skip, record walk, match and count tracking
`default_nettype none

module tlvss_parse #(
    parameter int HEADER_BYTES      = tlvss_pkg::HEADER_BYTES_DEF,
    parameter int MAX_MESSAGE_BYTES = tlvss_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_last,
    input  wire logic [7:0]           i_target,
    output tlvss_pkg::t_result        o_result
);
    import tlvss_pkg::*;

    localparam int PosCapInt = (MAX_MESSAGE_BYTES - 1 > 4095) ? 4095 : MAX_MESSAGE_BYTES - 1;
    localparam logic [POS_W-1:0] POS_CAP   = POS_W'(PosCapInt);
    localparam logic [POS_W:0]   SHORT_POS = (POS_W + 1)'(HEADER_BYTES + MIN_BODY_BYTES - 1);
    localparam logic [HDR_W-1:0] HDR_INIT  = HDR_W'(HEADER_BYTES);

    logic [POS_W-1:0]   r_pos,     n_pos;
    logic [PHASE_W-1:0] r_phase,   n_phase;
    logic [HDR_W-1:0]   r_hdr,     n_hdr;
    logic [7:0]         r_len_lo,  n_len_lo;
    logic [LEN_W-1:0]   r_payload, n_payload;
    logic [POS_W-1:0]   r_count,   n_count;
    logic               r_match,   n_match;
    logic [POS_W-1:0]   r_moff,    n_moff;
    logic [LEN_W-1:0]   w_dec;
    logic [LEN_W-1:0]   w_len;
    logic               w_short;

    assign w_dec   = r_payload - LEN_W'(r_payload != '0);
    assign w_len   = {i_byte, r_len_lo};
    assign w_short = {1'b0, r_pos} < SHORT_POS;

    always_comb begin
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_hdr     = r_hdr;
        n_len_lo  = r_len_lo;
        n_payload = r_payload;
        n_count   = r_count;
        n_match   = r_match;
        n_moff    = r_moff;
        unique case (r_phase)
            PH_ID: begin
                if (r_count != '1) begin
                    n_count = r_count + POS_W'(1);
                end
                if (!r_match && (i_byte == i_target)) begin
                    n_match = 1'b1;
                    n_moff  = r_pos;
                end
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len_lo = i_byte;
                n_phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_payload = w_len;
                n_phase   = (w_len != '0) ? PH_PAYLOAD : PH_ID;
            end
            PH_PAYLOAD: begin
                n_payload = w_dec;
                if (w_dec == '0) begin
                    n_phase = PH_ID;
                end
            end
            default: begin
                if (r_hdr <= HDR_W'(1)) begin
                    n_hdr   = '0;
                    n_phase = PH_ID;
                end else begin
                    n_hdr   = r_hdr - HDR_W'(1);
                    n_phase = PH_HEADER;
                end
            end
        endcase
        if (r_pos < POS_CAP) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_comb begin
        if (w_short) begin
            o_result.found        = 1'b0;
            o_result.found_offset = '0;
            o_result.record_count = '0;
            o_result.status       = ST_SHORT;
        end else begin
            o_result.found        = n_match;
            o_result.found_offset = n_match ? n_moff : '0;
            o_result.record_count = n_count;
            o_result.status       = (n_phase == PH_ID) ? ST_OK : ST_OVERRUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_pos     <= '0;
            r_phase   <= PH_HEADER;
            r_hdr     <= HDR_INIT;
            r_len_lo  <= '0;
            r_payload <= '0;
            r_count   <= '0;
            r_match   <= 1'b0;
            r_moff    <= '0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_phase   <= n_phase;
            r_hdr     <= n_hdr;
            r_len_lo  <= n_len_lo;
            r_payload <= n_payload;
            r_count   <= n_count;
            r_match   <= n_match;
            r_moff    <= n_moff;
        end
    end

endmodule

`default_nettype wire

FILE: src/tlvss_out_reg.sv
// result register with valid/ready hand-off
`default_nettype none

module tlvss_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire tlvss_pkg::t_result i_result,
    input  wire logic               i_ready,
    output logic                    o_valid,
    output logic                    o_free,
    output tlvss_pkg::t_result      o_result
);
    import tlvss_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_valid  = r_valid;
    assign o_free   = !r_valid || i_ready;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

FILE: src/tlvss_top_placeholder_unused.sv
// byte input register stage feeding the parser
`default_nettype none

module tlvss_in_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire logic       i_step,
    output logic            o_ready,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    assign o_ready = !r_valid || i_step;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_step) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

endmodule

`default_nettype wire

FILE: src/tlv_stream_scanner_core.sv
// top level of the tlv stream scanner
// a final byte's result is registered in the input stage and then in the result register before it is valid
// throughput: one byte per cycle; a final byte waits while the previous result is still held
// target id writes complete in the cycle they are offered
// synchronous active-low reset clears the parse state, the target id and both stages
`default_nettype none

module tlv_stream_scanner_core #(
    parameter int HEADER_BYTES      = tlvss_pkg::HEADER_BYTES_DEF,
    parameter int MAX_MESSAGE_BYTES = tlvss_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [7:0]                         i_data_byte,
    input  wire logic                               i_last_byte,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_found,
    output logic [tlvss_pkg::POS_W-1:0]             o_found_offset,
    output logic [tlvss_pkg::POS_W-1:0]             o_record_count,
    output logic [tlvss_pkg::STATUS_W-1:0]          o_status,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [7:0]                         i_cfg_target_id
);
    import tlvss_pkg::*;

    `include "assert_macros.svh"

    logic [7:0] r_target;
    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_in_last;
    logic       w_out_free;
    logic       w_step;
    t_result    w_result;
    t_result    w_out_result;

    assign o_cfg_ready = 1'b1;
    assign w_step      = w_in_valid && (!w_in_last || w_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_target <= i_cfg_target_id;
        end
    end

    tlvss_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_data_byte),
        .i_last  (i_last_byte),
        .i_step  (w_step),
        .o_ready (o_in_ready),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte),
        .o_last  (w_in_last)
    );

    tlvss_parse #(
        .HEADER_BYTES      (HEADER_BYTES),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (w_in_byte),
        .i_last   (w_in_last),
        .i_target (r_target),
        .o_result (w_result)
    );

    tlvss_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step && w_in_last),
        .i_result (w_result),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_free   (w_out_free),
        .o_result (w_out_result)
    );

    assign o_found        = w_out_result.found;
    assign o_found_offset = w_out_result.found_offset;
    assign o_record_count = w_out_result.record_count;
    assign o_status       = w_out_result.status;

    // a waiting result is never overwritten
    `ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n,
        w_in_valid && w_in_last && o_out_valid && !i_out_ready, !w_step)
    // short messages report nothing else
    `ASSERT_IMPLIES(a_short_empty, i_clk, i_rst_n, o_out_valid && (o_status == ST_SHORT),
        !o_found && (o_found_offset == '0) && (o_record_count == '0))
    // no match means zero offset
    `ASSERT_IMPLIES(a_nofind_zero, i_clk, i_rst_n, o_out_valid && !o_found,
        o_found_offset == '0)
    // a match lies past the header and implies a counted record
    `ASSERT_IMPLIES(a_find_past_hdr, i_clk, i_rst_n, o_out_valid && o_found,
        (o_found_offset >= POS_W'(HEADER_BYTES)) && (o_record_count != '0))

endmodule

`default_nettype wire

FILE: bench/tb_tlv_stream_scanner_core.sv
// self-checking testbench for tlv_stream_scanner_core: directed table, random messages, scoreboard
module tb_tlv_stream_scanner_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tlvss_pkg::*;

    localparam int HDR         = HEADER_BYTES_DEF;
    localparam int MAX_MSG     = MAX_MESSAGE_BYTES_DEF;
    localparam int POS_CAP     = (MAX_MSG - 1 > 4095) ? 4095 : MAX_MSG - 1;
    localparam int COUNT_CAP   = 4095;
    localparam int SETTLE      = 6;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam t_result NO_RES = '0;

    typedef logic [7:0] t_byte_q [$];

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        t_result    want;
    } t_dir_row;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [7:0]          in_data = 8'h00;
    logic                in_last = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                res_found;
    logic [POS_W-1:0]    res_offset;
    logic [POS_W-1:0]    res_count;
    logic [STATUS_W-1:0] res_status;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [7:0]          cfg_target = 8'h00;

    // predictor copy of the scanner
    logic [7:0]         scan_target = 8'h00;
    logic [POS_W-1:0]   msg_pos;
    logic [PHASE_W-1:0] phase;
    logic [HDR_W-1:0]   hdr_left;
    logic [7:0]         len_lo;
    logic [LEN_W-1:0]   pay_left;
    logic [POS_W-1:0]   rec_count;
    logic               hit_seen;
    logic [POS_W-1:0]   hit_offset;

    t_result pending_results [$];
    bit      dir_check = 1'b0;
    t_result dir_want = '0;

    int in_idle_pct = 0;
    int out_idle_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int bytes_taken = 0;
    int results_checked = 0;
    int messages_sent = 0;
    int target_writes = 0;
    int mismatch_count = 0;

    t_dir_row dir_rows [23] = '{
        '{8'hFF, 1'b1, 1'b1, {1'b0, 12'd0, 12'd0, ST_SHORT}},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'h55, 1'b0, 1'b0, NO_RES},
        '{8'hAA, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h80, 1'b0, 1'b0, NO_RES},
        '{8'h7F, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h01, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b1, 1'b1, {1'b1, 12'd7, 12'd1, ST_OK}},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b1, 1'b1, {1'b0, 12'd0, 12'd1, ST_OVERRUN}}
    };

    tlv_stream_scanner_core #(
        .HEADER_BYTES      (HDR),
        .MAX_MESSAGE_BYTES (MAX_MSG)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_data_byte     (in_data),
        .i_last_byte     (in_last),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_found         (res_found),
        .o_found_offset  (res_offset),
        .o_record_count  (res_count),
        .o_status        (res_status),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_target_id (cfg_target)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_scan();
        msg_pos    = '0;
        phase      = PH_HEADER;
        hdr_left   = HDR_W'(HDR);
        len_lo     = '0;
        pay_left   = '0;
        rec_count  = '0;
        hit_seen   = 1'b0;
        hit_offset = '0;
    endfunction

    function automatic bit scan_byte(input logic [7:0] b, input logic last, output t_result res);
        logic [POS_W-1:0] pos;
        int               msg_len;
        pos = msg_pos;
        res = '0;
        case (phase)
            PH_ID: begin
                if (rec_count < POS_W'(COUNT_CAP))
                    rec_count = rec_count + 1'b1;
                if (!hit_seen && b == scan_target) begin
                    hit_seen   = 1'b1;
                    hit_offset = pos;
                end
                phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_lo = b;
                phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                pay_left = {b, len_lo};
                phase    = (pay_left != 0) ? PH_PAYLOAD : PH_ID;
            end
            PH_PAYLOAD: begin
                if (pay_left > 0)
                    pay_left = pay_left - 1'b1;
                if (pay_left == 0)
                    phase = PH_ID;
            end
            default: begin
                if (hdr_left <= 1) begin
                    hdr_left = '0;
                    phase    = PH_ID;
                end else begin
                    hdr_left = hdr_left - 1'b1;
                    phase    = PH_HEADER;
                end
            end
        endcase
        if (msg_pos < POS_W'(POS_CAP))
            msg_pos = msg_pos + 1'b1;
        if (!last)
            return 1'b0;
        msg_len = int'(pos) + 1;
        if (msg_len < HDR + MIN_BODY_BYTES) begin
            res.status = ST_SHORT;
        end else begin
            res.status       = (phase == PH_ID) ? ST_OK : ST_OVERRUN;
            res.found        = hit_seen;
            res.found_offset = hit_seen ? hit_offset : '0;
            res.record_count = rec_count;
        end
        clear_scan();
        return 1'b1;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] error: %s", $realtime, msg);
    endtask

    always @(posedge clk) begin
        t_result pred;
        t_result got;
        t_result want;
        cycle_count++;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                scan_target = cfg_target;
                target_writes++;
            end
            if (in_valid && in_ready) begin
                bytes_taken++;
                if (scan_byte(in_data, in_last, pred))
                    pending_results.push_back(dir_check ? dir_want : pred);
            end
            if (out_valid && out_ready) begin
                got = {res_found, res_offset, res_count, res_status};
                results_checked++;
                if (pending_results.size() == 0) begin
                    log_mismatch($sformatf("unexpected result found=%0d off=%0d cnt=%0d st=%0d",
                        got.found, got.found_offset, got.record_count, got.status));
                end else begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found || got.found_offset !== want.found_offset ||
                        got.record_count !== want.record_count || got.status !== want.status)
                        log_mismatch($sformatf(
                            "result %0d got found=%0d off=%0d cnt=%0d st=%0d, want %0d/%0d/%0d/%0d",
                            results_checked, got.found, got.found_offset, got.record_count,
                            got.status, want.found, want.found_offset, want.record_count,
                            want.status));
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver side: random stalls plus a counted hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic l);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        in_last  <= l;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_message(input t_byte_q m);
        foreach (m[i])
            push_byte(m[i], i == m.size() - 1);
        messages_sent++;
    endtask

    task automatic write_target(input logic [7:0] tgt);
        cfg_valid  <= 1'b1;
        cfg_target <= tgt;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_id();
        return ($urandom_range(3) == 0) ? scan_target : 8'($urandom);
    endfunction

    function automatic t_byte_q random_message();
        t_byte_q m;
        int      kind;
        int      len;
        int      cut;
        kind = $urandom_range(99);
        if (kind >= 85) begin
            repeat ($urandom_range(1, HDR + MIN_BODY_BYTES + 3)) m.push_back(8'($urandom));
            return m;
        end
        repeat (HDR) m.push_back(8'($urandom));
        repeat ($urandom_range(0, 5)) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            m.push_back(pick_id());
            m.push_back(8'(len));
            m.push_back(8'(len >> 8));
            repeat (len) m.push_back(8'($urandom));
        end
        if (kind >= 70) begin
            // truncated record at the end
            len = $urandom_range(1, 65535);
            cut = $urandom_range(1, 4);
            m.push_back(pick_id());
            if (cut >= 2)
                m.push_back(8'(len));
            if (cut >= 3)
                m.push_back(8'(len >> 8));
            if (cut == 4)
                repeat ($urandom_range(0, (len > 5) ? 5 : len - 1)) m.push_back(8'($urandom));
        end
        return m;
    endfunction

    task automatic run_phase(input int in_pct, input int out_pct, input logic [7:0] tgt,
                             input int byte_goal);
        t_byte_q m;
        int      sent;
        int      msgs;
        sent = 0;
        msgs = 0;
        wait_drain();
        write_target(tgt);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        while (sent < byte_goal || msgs < 4) begin
            m = random_message();
            send_message(m);
            sent += m.size();
            msgs++;
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        t_byte_q m;
        clear_scan();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        write_target(8'h00);

        foreach (dir_rows[i]) begin
            dir_check = dir_rows[i].typed;
            dir_want  = dir_rows[i].want;
            push_byte(dir_rows[i].data, dir_rows[i].last);
        end
        in_valid <= 1'b0;
        dir_check = 1'b0;

        run_phase(9, 61, 8'hFF, 220);
        run_phase(61, 9, 8'($urandom), 220);
        run_phase(0, 0, 8'($urandom), 220);

        // hold the receiver off while short messages keep coming
        wait_drain();
        write_target(8'($urandom));
        in_idle_pct  = 0;
        out_idle_pct = 20;
        hold_left    = 300;
        for (int k = 0; k < 40; k++) begin
            if (k % 8 == 0) begin
                m = random_message();
            end else begin
                m.delete();
                m.push_back(8'($urandom));
            end
            send_message(m);
        end
        in_valid <= 1'b0;

        wait_drain();
        if (pending_results.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        $display("run covered %0d messages in %0d bytes, %0d results compared",
                 messages_sent, bytes_taken, results_checked);
        $display("target id set %0d times; short, overrun, matching and stalled cases exercised",
                 target_writes);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/tlvss_pkg.sv
src/tlvss_parse.sv
src/tlvss_out_reg.sv
src/tlvss_top_placeholder_unused.sv
src/tlv_stream_scanner_core.sv
bench/tb_tlv_stream_scanner_core.sv
